// ===== rtl/lpfr_pkg.sv =====
package lpfr_pkg;

  // Defaults for the top-level parameters
  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 16;
  localparam int TIME_BITS_DEF = 32;

  // Fixed field widths
  localparam int PAGE_NUMBER_W = 16;
  localparam int FRAME_INDEX_W = 4;
  localparam int FAULT_W       = 32;
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  // Configuration register
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = 5'd16;

  // APB-style port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_UPDATE
  } lpfr_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the referenced page, clear search results
    logic rd_en;   // read one frame entry this cycle
    logic commit;  // write the chosen frame, counters and result
  } lpfr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_stall;  // result register still occupied
  } lpfr_sts_t;

endpackage

// ===== rtl/lpfr_ctrl.sv =====
module lpfr_ctrl #(
  parameter int FRAMES = lpfr_pkg::FRAMES_DEF,
  parameter int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  parameter int CNT_W  = $clog2(FRAMES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CNT_W-1:0]    frame_cnt_i,
  output logic [IDX_W-1:0]    rd_addr_o,
  output lpfr_pkg::lpfr_cmd_t cmd_o,
  input  lpfr_pkg::lpfr_sts_t sts_i
);
  import lpfr_pkg::*;

  lpfr_state_e state_q, state_d;
  logic [IDX_W-1:0] scan_q, scan_d;
  logic [CNT_W-1:0] scan_next;
  logic             scan_last;

  assign scan_next = CNT_W'(scan_q) + CNT_W'(1);
  assign scan_last = (scan_next == frame_cnt_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    case (state_q)
      ST_IDLE: begin
        scan_d = '0;
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_d = IDX_W'(scan_next);
        if (scan_last) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!sts_i.out_stall) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    rd_addr_o    = scan_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
      end
      ST_LAST: begin
      end
      ST_UPDATE: begin
        cmd_o.commit = !sts_i.out_stall;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/lpfr_dp.sv =====
module lpfr_dp #(
  parameter int FRAMES    = lpfr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lpfr_pkg::PAGE_BITS_DEF,
  parameter int TIME_BITS = lpfr_pkg::TIME_BITS_DEF,
  parameter int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [lpfr_pkg::PAGE_NUMBER_W-1:0]   page_number_i,
  input  logic [IDX_W-1:0]                     rd_addr_i,
  input  lpfr_pkg::lpfr_cmd_t                  cmd_i,
  output lpfr_pkg::lpfr_sts_t                  sts_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 hit_o,
  output logic [lpfr_pkg::FRAME_INDEX_W-1:0]   frame_index_o,
  output logic [lpfr_pkg::FAULT_W-1:0]         fault_count_o
);
  import lpfr_pkg::*;

  // Frame table storage
  logic [PAGE_BITS-1:0] page_mem [FRAMES];
  logic [TIME_BITS-1:0] time_mem [FRAMES];
  logic [FRAMES-1:0]    valid_q;

  // Read pipeline
  logic [PAGE_BITS-1:0] rd_page_q;
  logic [TIME_BITS-1:0] rd_time_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic                 rd_vld_q;

  // Search results
  logic [PAGE_BITS-1:0] page_q;
  logic                 hit_found_q, empty_found_q;
  logic [IDX_W-1:0]     hit_idx_q, empty_idx_q, min_idx_q;
  logic [TIME_BITS-1:0] min_time_q;

  logic [TIME_BITS-1:0] clock_q;
  logic [FAULT_W-1:0]   faults_q, faults_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_hit_q;
  logic [FRAME_INDEX_W-1:0] out_frame_q;
  logic [FAULT_W-1:0]   out_faults_q;

  logic                 entry_vld, page_match, min_take;
  logic [IDX_W-1:0]     chosen;

  assign entry_vld  = valid_q[rd_idx_q];
  assign page_match = (rd_page_q == page_q);
  assign min_take   = (rd_idx_q == '0) || (rd_time_q < min_time_q);

  // Hit first, then lowest empty frame, then least recently used
  assign chosen = hit_found_q   ? hit_idx_q :
                  empty_found_q ? empty_idx_q : min_idx_q;

  assign faults_d = (!hit_found_q && (faults_q != FAULT_MAX)) ? faults_q + FAULT_W'(1)
                                                               : faults_q;

  // Memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      page_mem[chosen] <= page_q;
      time_mem[chosen] <= clock_q;
    end
    if (cmd_i.rd_en) begin
      rd_page_q <= page_mem[rd_addr_i];
      rd_time_q <= time_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
      clock_q  <= '0;
      faults_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q    <= cmd_i.rd_en;
      out_valid_q <= out_valid_d;
      if (cmd_i.commit) begin
        valid_q[chosen] <= 1'b1;
        clock_q  <= clock_q + TIME_BITS'(1);
        faults_q <= faults_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_found_q   <= 1'b0;
      empty_found_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_found_q   <= 1'b0;
      empty_found_q <= 1'b0;
    end else if (rd_vld_q) begin
      if (entry_vld && page_match && !hit_found_q) begin
        hit_found_q <= 1'b1;
      end
      if (!entry_vld && !empty_found_q) begin
        empty_found_q <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_addr_i;
    if (cmd_i.load) begin
      page_q <= PAGE_BITS'(page_number_i);
    end
    if (rd_vld_q) begin
      if (entry_vld && page_match && !hit_found_q) begin
        hit_idx_q <= rd_idx_q;
      end
      if (!entry_vld && !empty_found_q) begin
        empty_idx_q <= rd_idx_q;
      end
      if (min_take) begin
        min_idx_q  <= rd_idx_q;
        min_time_q <= rd_time_q;
      end
    end
    if (cmd_i.commit) begin
      out_hit_q    <= hit_found_q;
      out_frame_q  <= FRAME_INDEX_W'(chosen);
      out_faults_q <= faults_d;
    end
  end

  // Result register: commit is only issued once the slot is free
  assign out_valid_d = cmd_i.commit || (out_valid_q && !out_ready_i);
  assign sts_o.out_stall = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_hit_q;
  assign frame_index_o = out_frame_q;
  assign fault_count_o = out_faults_q;

endmodule

// ===== rtl/lru_page_frame_replacer.sv =====
// LRU page frame replacer: one page reference in, one hit/fault result out.
// A reference is accepted in idle, then N table entries are scanned (N is the
// effective frame count, 1..FRAMES), one entry per cycle, before a final compare
// and the commit. The next one is accepted only after that commit, which waits
// while the result register is not drained. Reset (rst_ni low, asynchronous)
// empties the table, clears the use clock and fault count, sets frames_in_use to 16.
module lru_page_frame_replacer #(
  parameter int FRAMES    = lpfr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lpfr_pkg::PAGE_BITS_DEF,
  parameter int TIME_BITS = lpfr_pkg::TIME_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lpfr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [lpfr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [lpfr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  // Page reference channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [lpfr_pkg::PAGE_NUMBER_W-1:0] page_number_i,
  // Result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               hit_o,
  output logic [lpfr_pkg::FRAME_INDEX_W-1:0] frame_index_o,
  output logic [lpfr_pkg::FAULT_W-1:0]       fault_count_o
);
  import lpfr_pkg::*;

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);
  // Width wide enough for both the register value and the frame count
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0] frames_in_use_q;
  logic             cfg_wr;
  logic [CMP_W-1:0] cfg_wide;
  logic [CNT_W-1:0] frame_cnt;

  lpfr_cmd_t        cmd;
  lpfr_sts_t        sts;
  logic [IDX_W-1:0] rd_addr;

  // Register write on the access phase; the index is the word address
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= CFG_FRAMES_RESET;
    end else if (cfg_wr && (paddr[2] == REG_FRAMES_IN_USE)) begin
      frames_in_use_q <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FRAMES_IN_USE) begin
      prdata = APB_DATA_W'(frames_in_use_q);
    end
  end

  // Clamp the frame count: zero acts as one, anything above FRAMES as FRAMES
  assign cfg_wide = CMP_W'(frames_in_use_q);
  always_comb begin
    if (cfg_wide == '0) begin
      frame_cnt = CNT_W'(1);
    end else if (cfg_wide > CMP_W'(FRAMES)) begin
      frame_cnt = CNT_W'(FRAMES);
    end else begin
      frame_cnt = CNT_W'(cfg_wide);
    end
  end

  // Controller: sequences accept, table scan, final compare and update
  lpfr_ctrl #(
    .FRAMES (FRAMES),
    .IDX_W  (IDX_W),
    .CNT_W  (CNT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .frame_cnt_i (frame_cnt),
    .rd_addr_o   (rd_addr),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Datapath: frame table, search registers, counters and result register
  lpfr_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .TIME_BITS (TIME_BITS),
    .IDX_W     (IDX_W)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .page_number_i (page_number_i),
    .rd_addr_i     (rd_addr),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hit_o         (hit_o),
    .frame_index_o (frame_index_o),
    .fault_count_o (fault_count_o)
  );

endmodule
